// ===== rtl/first_order_lowpass_filter_unit_macros.svh =====
// ============================================================================
// First-order low-pass filter unit: assertion macros
// Shared concurrent assertion forms for the filter RTL.
// ============================================================================
`ifndef FIRST_ORDER_LOWPASS_FILTER_UNIT_MACROS_SVH
`define FIRST_ORDER_LOWPASS_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FLPF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FLPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/flpf_pkg.sv =====
// ============================================================================
// First-order low-pass filter package
// Register indexes, mode codes, reset values, sequencer and ALU types.
// ============================================================================
package flpf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MODE_W     = 2;
    localparam int SHIFT_W    = 4;
    localparam int GAIN_W     = 16;
    localparam int FREQ_W     = 14;
    localparam int Q_SHIFT    = 15;
    localparam int COEF_W     = 16;
    localparam int REM_W      = 15;
    localparam int DEN_W      = 15;
    localparam int STEP_CNT_W = 4;

    localparam logic [STEP_CNT_W-1:0] STEP_LAST = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 3'd5;

    localparam logic [MODE_W-1:0] MODE_SHIFT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GAIN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CUTOFF = 2'd2;

    localparam logic [SHIFT_W-1:0] RST_SHIFT  = 4'd4;
    localparam logic [GAIN_W-1:0]  RST_GAIN   = 16'd32768;
    localparam logic [FREQ_W-1:0]  RST_CUTOFF = 14'd1;
    localparam logic [FREQ_W-1:0]  RST_RATE   = 14'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_MULTIPLY,
        ST_FINISH
    } t_state;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
        logic    first;
    } t_alu_ctl;

endpackage

// ===== rtl/first_order_lowpass_filter_unit.sv =====
// ============================================================================
// First-order low-pass filter unit
// Integrator-form IIR low-pass with shift, fixed-gain and cutoff-derived gain.
// ============================================================================
// Samples enter on the i_sample valid/ready channel and one filtered word
// leaves on the o_filtered valid/ready channel for every sample taken.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_wdata;
// the user writes it only while the unit is idle; the unit does not enforce this.
// The unit takes one sample at a time; o_sample_ready is high only when idle.
// Shift mode and the disabled case go from the update step straight to the
// final step, which loads the result register.
// Gain mode runs 16 shift-add steps on the shared adder, then the final step.
// Cutoff mode reuses a cached coefficient; after cutoff or sample_rate is
// written the next sample first runs 16 restoring divide steps on the same
// adder, recomputing the coefficient once before the multiply steps.
// The result register frees the input side: a stalled receiver only holds
// the sequencer in its final step until the previous word is taken.
// Reset clears the accumulator and the last output, invalidates the cached
// coefficient and loads the register defaults; no word is pending afterward.
// ============================================================================
`include "first_order_lowpass_filter_unit_macros.svh"

module first_order_lowpass_filter_unit import flpf_pkg::*; #(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                         i_sample_valid,
    output logic                         o_sample_ready,
    input  logic signed [DATA_WIDTH-1:0] i_sample,
    output logic                         o_filtered_valid,
    input  logic                         i_filtered_ready,
    output logic signed [DATA_WIDTH-1:0] o_filtered
);

    localparam int PROD_W = ACC_WIDTH + COEF_W + 1;
    localparam int SUM_W  = ((ACC_WIDTH > DATA_WIDTH + 1) ? ACC_WIDTH : DATA_WIDTH + 1) + 2;
    localparam int SAT_W  = ((ACC_WIDTH + 2 > DATA_WIDTH) ? ACC_WIDTH + 2 : DATA_WIDTH) + 1;

    localparam logic signed [SUM_W-1:0] A_MAX =
        {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] A_MIN = ~A_MAX;
    localparam logic signed [SAT_W-1:0] Y_MAX =
        {{(SAT_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] Y_MIN = ~Y_MAX;

    t_state r_state, n_state;

    logic                         r_enable;
    logic [MODE_W-1:0]            r_mode;
    logic [SHIFT_W-1:0]           r_shift;
    logic [GAIN_W-1:0]            r_gain;
    logic [FREQ_W-1:0]            r_cutoff;
    logic [FREQ_W-1:0]            r_rate;

    logic [COEF_W-1:0]            r_k, n_k;
    logic                         r_k_ok, n_k_ok;
    logic signed [ACC_WIDTH-1:0]  r_acc, n_acc;
    logic signed [DATA_WIDTH-1:0] r_last, n_last;
    logic signed [DATA_WIDTH-1:0] r_sample, n_sample;
    logic [PROD_W-1:0]            r_prod, n_prod;
    logic [REM_W-1:0]             r_rem, n_rem;
    logic [COEF_W-1:0]            r_quo, n_quo;
    logic [STEP_CNT_W-1:0]        r_cnt, n_cnt;
    logic                         r_out_valid, n_out_valid;
    logic signed [DATA_WIDTH-1:0] r_filtered, n_filtered;

    logic                         c_accept;
    logic                         c_out_free;
    logic                         c_mul_mode;
    logic                         c_k_clear;
    logic [DEN_W-1:0]             c_den;
    logic [COEF_W-1:0]            c_quo_done;
    logic signed [SUM_W-1:0]      c_sum;
    logic signed [ACC_WIDTH-1:0]  c_acc_sat;
    logic signed [ACC_WIDTH+1:0]  c_prod_q;
    logic signed [ACC_WIDTH-1:0]  c_shifted;
    logic signed [SAT_W-1:0]      c_y_ext;
    logic signed [DATA_WIDTH-1:0] c_y;

    t_alu_ctl                     alu_ctl;
    logic [PROD_W-1:0]            alu_prod;
    logic [REM_W-1:0]             alu_rem;
    logic                         alu_qbit;

    assign c_accept   = i_sample_valid && o_sample_ready;
    assign c_out_free = !r_out_valid || i_filtered_ready;
    assign c_mul_mode = (r_mode == MODE_GAIN) || (r_mode == MODE_CUTOFF);
    assign c_k_clear  = i_cfg_we && ((i_cfg_idx == CFG_CUTOFF) || (i_cfg_idx == CFG_RATE));

    assign alu_ctl.op    = (r_state == ST_DIVIDE) ? ALU_DIV : ALU_MUL;
    assign alu_ctl.first = (r_cnt == '0);

    flpf_alu #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_alu (
        .i_ctl  (alu_ctl),
        .i_acc  (r_acc),
        .i_prod (r_prod),
        .i_rem  (r_rem),
        .i_den  (c_den),
        .o_prod (alu_prod),
        .o_rem  (alu_rem),
        .o_qbit (alu_qbit)
    );

    always_comb begin
        c_den      = {1'b0, r_cutoff} + {1'b0, r_rate};
        c_quo_done = (c_den == '0) ? '0 : {r_quo[COEF_W-2:0], alu_qbit};

        c_sum = SUM_W'(r_acc) + SUM_W'(r_sample) - SUM_W'(r_last);
        if (c_sum > A_MAX) begin
            c_acc_sat = A_MAX[ACC_WIDTH-1:0];
        end else if (c_sum < A_MIN) begin
            c_acc_sat = A_MIN[ACC_WIDTH-1:0];
        end else begin
            c_acc_sat = c_sum[ACC_WIDTH-1:0];
        end

        c_prod_q  = r_prod[PROD_W-1:Q_SHIFT];
        c_shifted = r_acc >>> r_shift;
        c_y_ext   = c_mul_mode ? SAT_W'(c_prod_q) : SAT_W'(c_shifted);
        if (c_y_ext > Y_MAX) begin
            c_y = Y_MAX[DATA_WIDTH-1:0];
        end else if (c_y_ext < Y_MIN) begin
            c_y = Y_MIN[DATA_WIDTH-1:0];
        end else begin
            c_y = c_y_ext[DATA_WIDTH-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (c_accept) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!r_enable) begin
                    n_state = ST_FINISH;
                end else if (r_mode == MODE_GAIN) begin
                    n_state = ST_MULTIPLY;
                end else if (r_mode == MODE_CUTOFF) begin
                    n_state = r_k_ok ? ST_MULTIPLY : ST_DIVIDE;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_DIVIDE: begin
                if (r_cnt == STEP_LAST) begin
                    n_state = ST_MULTIPLY;
                end
            end
            ST_MULTIPLY: begin
                if (r_cnt == STEP_LAST) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (c_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_k         = r_k;
        n_k_ok      = r_k_ok;
        n_acc       = r_acc;
        n_last      = r_last;
        n_sample    = r_sample;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_filtered_ready;
        n_filtered  = r_filtered;
        case (r_state)
            ST_IDLE: begin
                if (c_accept) begin
                    n_sample = i_sample;
                end
            end
            ST_UPDATE: begin
                n_cnt = '0;
                n_rem = REM_W'(r_cutoff);
                if (!r_enable) begin
                    n_acc  = '0;
                    n_last = '0;
                end else begin
                    n_acc = c_acc_sat;
                end
                if (r_mode == MODE_GAIN) begin
                    n_prod = {{(ACC_WIDTH+1){1'b0}}, r_gain};
                end else begin
                    n_prod = {{(ACC_WIDTH+1){1'b0}}, r_k};
                end
            end
            ST_DIVIDE: begin
                n_rem = alu_rem;
                n_quo = {r_quo[COEF_W-2:0], alu_qbit};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_LAST) begin
                    n_k    = c_quo_done;
                    n_k_ok = 1'b1;
                    n_prod = {{(ACC_WIDTH+1){1'b0}}, c_quo_done};
                end
            end
            ST_MULTIPLY: begin
                n_prod = alu_prod;
                n_cnt  = r_cnt + 1'b1;
            end
            ST_FINISH: begin
                if (c_out_free) begin
                    n_out_valid = 1'b1;
                    n_filtered  = r_enable ? c_y : '0;
                    n_last      = r_enable ? c_y : '0;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_mode   <= MODE_SHIFT;
            r_shift  <= RST_SHIFT;
            r_gain   <= RST_GAIN;
            r_cutoff <= RST_CUTOFF;
            r_rate   <= RST_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: r_enable <= i_cfg_wdata[0];
                CFG_MODE:   r_mode   <= i_cfg_wdata[MODE_W-1:0];
                CFG_SHIFT:  r_shift  <= i_cfg_wdata[SHIFT_W-1:0];
                CFG_GAIN:   r_gain   <= i_cfg_wdata[GAIN_W-1:0];
                CFG_CUTOFF: r_cutoff <= i_cfg_wdata[FREQ_W-1:0];
                CFG_RATE:   r_rate   <= i_cfg_wdata[FREQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k_ok      <= 1'b0;
            r_acc       <= '0;
            r_last      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k_ok      <= c_k_clear ? 1'b0 : n_k_ok;
            r_acc       <= n_acc;
            r_last      <= n_last;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_sample   <= n_sample;
        r_prod     <= n_prod;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_filtered <= n_filtered;
    end

    assign o_sample_ready   = (r_state == ST_IDLE);
    assign o_filtered_valid = r_out_valid;
    assign o_filtered       = r_filtered;

    `FLPF_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, c_accept, r_state == ST_UPDATE, "Accepted sample did not start an update.")
    `FLPF_ASSERT_NEXT(a_disable_clears, i_clk, i_rst_n, r_state == ST_UPDATE && !r_enable, r_acc == '0 && r_last == '0 && r_state == ST_FINISH, "Disabled step did not clear the filter state.")
    `FLPF_ASSERT_NEXT(a_divide_to_mul, i_clk, i_rst_n, r_state == ST_DIVIDE && r_cnt == STEP_LAST, r_state == ST_MULTIPLY, "Divide did not hand over to the multiply.")
    `FLPF_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, r_state == ST_FINISH && c_out_free, r_out_valid && r_state == ST_IDLE, "Finished word was not loaded into the output register.")
    `FLPF_ASSERT_NEXT(a_out_source, i_clk, i_rst_n, !r_out_valid && r_state != ST_FINISH, !r_out_valid, "Output word appeared outside the final step.")

endmodule

// ===== rtl/flpf_alu.sv =====
// ============================================================================
// First-order low-pass filter shared step unit
// One adder serves a restoring divide step and a shift-add multiply step.
// ============================================================================
module flpf_alu import flpf_pkg::*; #(
    parameter int ACC_WIDTH = 32
) (
    input  t_alu_ctl                          i_ctl,
    input  logic signed [ACC_WIDTH-1:0]       i_acc,
    input  logic        [ACC_WIDTH+COEF_W:0]  i_prod,
    input  logic        [REM_W-1:0]           i_rem,
    input  logic        [DEN_W-1:0]           i_den,
    output logic        [ACC_WIDTH+COEF_W:0]  o_prod,
    output logic        [REM_W-1:0]           o_rem,
    output logic                              o_qbit
);

    localparam int AW = ACC_WIDTH + 1;

    logic [REM_W:0] trial;
    logic [AW-1:0]  opa;
    logic [AW-1:0]  opb;
    logic [AW-1:0]  sum;
    logic           sub;

    always_comb begin
        trial = i_ctl.first ? {1'b0, i_rem} : {i_rem, 1'b0};
        sub   = (i_ctl.op == ALU_DIV);
        if (sub) begin
            opa = AW'(trial);
            opb = ~AW'(i_den);
        end else begin
            opa = i_prod[ACC_WIDTH+COEF_W -: AW];
            opb = i_prod[0] ? AW'(i_acc) : '0;
        end
        sum    = opa + opb + AW'(sub);
        o_qbit = sub & ~sum[AW-1];
        o_rem  = o_qbit ? sum[REM_W-1:0] : trial[REM_W-1:0];
        o_prod = {sum[AW-1], sum, i_prod[COEF_W-1:1]};
    end

endmodule

// ===== tb/sv/first_order_lowpass_filter_unit_tb.sv =====
// ============================================================================
// First-order low-pass filter unit testbench
// Sends sample words, writes the filter registers between phases and checks
// every filtered word against a cycle-free model of the integrator or a
// planned value, under random stalls on both handshakes except in the last run.
// ============================================================================
module first_order_lowpass_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import flpf_pkg::*;

    localparam int DW = 16;
    localparam int AW = 32;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam longint ACC_MAX = (longint'(1) << (AW - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint OUT_MAX = (longint'(1) << (DW - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;

    localparam logic signed [DW-1:0] SMP_MAX = 16'sh7fff;
    localparam logic signed [DW-1:0] SMP_MIN = 16'sh8000;

    typedef struct packed {
        logic                    is_reg;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   value;
        logic signed [DW-1:0]    smp;
        logic                    typed;
        logic signed [DW-1:0]    result;
    } t_plan_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;
    logic                    i_sample_valid = 1'b0;
    logic                    o_sample_ready;
    logic signed [DW-1:0]    i_sample = '0;
    logic                    o_filtered_valid;
    logic                    i_filtered_ready = 1'b0;
    logic signed [DW-1:0]    o_filtered;

    logic                    row_typed = 1'b0;
    logic signed [DW-1:0]    row_result = '0;

    logic                    cfg_enable;
    logic [MODE_W-1:0]       cfg_mode;
    logic [SHIFT_W-1:0]      cfg_shift;
    logic [GAIN_W-1:0]       cfg_gain;
    logic [FREQ_W-1:0]       cfg_cutoff;
    logic [FREQ_W-1:0]       cfg_rate;
    longint                  acc_q = 0;
    longint                  last_q = 0;

    logic signed [DW-1:0]    filtered_q[$];
    logic signed [DW-1:0]    predicted_word;
    logic signed [DW-1:0]    expected_word;
    t_plan_row               plan[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_samples = 0;
    int n_checked = 0;
    int n_writes = 0;
    int n_acc_clamps = 0;
    int n_errors = 0;

    logic signed [DW-1:0]    step_level = '0;
    int                      step_left = 0;
    bit                      step_noise = 1'b0;

    first_order_lowpass_filter_unit #(
        .DATA_WIDTH(DW),
        .ACC_WIDTH (AW)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_sample_valid  (i_sample_valid),
        .o_sample_ready  (o_sample_ready),
        .i_sample        (i_sample),
        .o_filtered_valid(o_filtered_valid),
        .i_filtered_ready(i_filtered_ready),
        .o_filtered      (o_filtered)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic logic signed [DW-1:0] lowpass_step(input logic signed [DW-1:0] x);
        longint sum;
        longint den;
        longint coef;
        longint y;
        if (!cfg_enable) begin
            acc_q = 0;
            last_q = 0;
            return '0;
        end
        sum = acc_q + (longint'(x) - last_q);
        if (sum > ACC_MAX || sum < ACC_MIN) n_acc_clamps++;
        acc_q = clamp(sum, ACC_MIN, ACC_MAX);
        case (cfg_mode)
            MODE_GAIN: begin
                y = (acc_q * longint'(cfg_gain)) >>> Q_SHIFT;
            end
            MODE_CUTOFF: begin
                den = longint'(cfg_cutoff) + longint'(cfg_rate);
                coef = (den == 0) ? 0 : (longint'(cfg_cutoff) << Q_SHIFT) / den;
                y = (acc_q * coef) >>> Q_SHIFT;
            end
            default: begin
                y = acc_q >>> cfg_shift;
            end
        endcase
        last_q = clamp(y, OUT_MIN, OUT_MAX);
        return DW'(last_q);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_enable = 1'b0;
            cfg_mode   = MODE_SHIFT;
            cfg_shift  = RST_SHIFT;
            cfg_gain   = RST_GAIN;
            cfg_cutoff = RST_CUTOFF;
            cfg_rate   = RST_RATE;
            acc_q      = 0;
            last_q     = 0;
        end else begin
            if (i_cfg_we) begin
                n_writes++;
                case (i_cfg_idx)
                    CFG_ENABLE: cfg_enable = i_cfg_wdata[0];
                    CFG_MODE:   cfg_mode   = i_cfg_wdata[MODE_W-1:0];
                    CFG_SHIFT:  cfg_shift  = i_cfg_wdata[SHIFT_W-1:0];
                    CFG_GAIN:   cfg_gain   = i_cfg_wdata[GAIN_W-1:0];
                    CFG_CUTOFF: cfg_cutoff = i_cfg_wdata[FREQ_W-1:0];
                    CFG_RATE:   cfg_rate   = i_cfg_wdata[FREQ_W-1:0];
                    default: ;
                endcase
            end
            if (i_sample_valid && o_sample_ready) begin
                predicted_word = lowpass_step(i_sample);
                filtered_q.push_back(row_typed ? row_result : predicted_word);
                n_samples++;
            end
            if (o_filtered_valid && i_filtered_ready) begin
                if (filtered_q.size() == 0) begin
                    if (n_errors < 100)
                        $display("%0t: filtered word %0d arrived with none expected",
                                 $time, o_filtered);
                    n_errors++;
                end else begin
                    expected_word = filtered_q.pop_front();
                    n_checked++;
                    if (o_filtered !== expected_word) begin
                        if (n_errors < 100)
                            $display("%0t: filtered word mismatch: expected %0d, actual %0d",
                                     $time, expected_word, o_filtered);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_filtered_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
    endtask

    task automatic send_word(input logic signed [DW-1:0] s, input logic typed,
                             input logic signed [DW-1:0] res);
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_sample_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_sample       <= s;
        row_typed      <= typed;
        row_result     <= res;
        i_sample_valid <= 1'b1;
        do @(posedge i_clk); while (!o_sample_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_sample_valid <= 1'b0;
        @(negedge i_clk);
        while (filtered_q.size() != 0 || !o_sample_ready) @(negedge i_clk);
    endtask

    function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] value);
        plan.push_back('{1'b1, idx, value, '0, 1'b0, '0});
    endfunction

    function automatic void plan_word(input logic signed [DW-1:0] s, input logic typed,
                                      input logic signed [DW-1:0] res);
        plan.push_back('{1'b0, '0, '0, s, typed, res});
    endfunction

    function automatic logic signed [DW-1:0] next_sample();
        int small_v;
        if (step_left == 0) begin
            step_left = $urandom_range(24, 1);
            step_noise = ($urandom_range(4) == 0);
            case ($urandom_range(3))
                0: step_level = $urandom_range(1) ? SMP_MAX : SMP_MIN;
                1: begin
                    small_v = $urandom_range(512);
                    step_level = DW'(small_v - 256);
                end
                default: step_level = DW'($urandom);
            endcase
        end
        step_left--;
        return step_noise ? DW'($urandom) : step_level;
    endfunction

    task automatic pick_settings();
        int v;
        if ($urandom_range(3) != 0) reg_write(CFG_ENABLE, CFG_DATA_W'($urandom_range(7) != 0));
        if ($urandom_range(3) != 0) reg_write(CFG_MODE, CFG_DATA_W'($urandom_range(3)));
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(3))
                0: v = 0;
                1: v = 15;
                default: v = $urandom_range(15);
            endcase
            reg_write(CFG_SHIFT, CFG_DATA_W'(v));
        end
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(4))
                0: v = 0;
                1: v = 32768;
                2: v = 65535;
                3: v = $urandom_range(32768);
                default: v = $urandom_range(65535);
            endcase
            reg_write(CFG_GAIN, CFG_DATA_W'(v));
        end
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(3))
                0: v = 0;
                1: v = 16383;
                default: v = $urandom_range(16383);
            endcase
            reg_write(CFG_CUTOFF, CFG_DATA_W'(v));
        end
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(3))
                0: v = 1;
                1: v = 16383;
                default: v = $urandom_range(16383, 1);
            endcase
            reg_write(CFG_RATE, CFG_DATA_W'(v));
        end
    endtask

    task automatic run_random_phases();
        for (int p = 0; p < 6; p++) begin
            drain();
            pick_settings();
            for (int n = 0; n < 55; n++) send_word(next_sample(), 1'b0, '0);
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        plan_word(SMP_MAX, 1'b1, 16'sd0);
        plan_word(SMP_MIN, 1'b1, 16'sd0);
        plan_reg(CFG_ENABLE, 16'd1);
        plan_reg(CFG_SHIFT, 16'd0);
        plan_word(SMP_MAX, 1'b1, SMP_MAX);
        plan_word(SMP_MIN, 1'b1, SMP_MIN);
        plan_reg(CFG_SHIFT, 16'd15);
        plan_word(SMP_MIN, 1'b1, -16'sd1);
        plan_word(SMP_MAX, 1'b0, '0);
        plan_reg(CFG_MODE, 16'(MODE_SPARE));
        plan_word(16'sd1000, 1'b0, '0);
        plan_word(-16'sd1, 1'b0, '0);
        plan_reg(CFG_MODE, 16'(MODE_GAIN));
        plan_reg(CFG_GAIN, 16'd65535);
        plan_word(SMP_MAX, 1'b0, '0);
        plan_word(SMP_MAX, 1'b0, '0);
        plan_reg(CFG_GAIN, 16'd0);
        plan_word(SMP_MIN, 1'b1, 16'sd0);
        plan_reg(CFG_GAIN, 16'd32768);
        plan_word(16'sd12345, 1'b0, '0);
        plan_reg(CFG_MODE, 16'(MODE_CUTOFF));
        plan_reg(CFG_CUTOFF, 16'd16383);
        plan_reg(CFG_RATE, 16'd1);
        plan_word(SMP_MAX, 1'b0, '0);
        plan_word(SMP_MIN, 1'b0, '0);
        plan_reg(CFG_CUTOFF, 16'd0);
        plan_word(16'sd20000, 1'b1, 16'sd0);
        plan_reg(CFG_RATE, 16'd0);
        plan_word(-16'sd20000, 1'b1, 16'sd0);
        plan_reg(CFG_RATE, 16'd16383);
        plan_reg(CFG_CUTOFF, 16'd1);
        plan_word(SMP_MAX, 1'b0, '0);
        plan_reg(CFG_ENABLE, 16'd0);
        plan_word(16'sd555, 1'b1, 16'sd0);
        plan_reg(CFG_ENABLE, 16'd1);
        plan_reg(CFG_MODE, 16'(MODE_SHIFT));
        plan_reg(CFG_SHIFT, 16'd4);
        plan_word(16'sd16, 1'b1, 16'sd1);
        plan_word(SMP_MIN, 1'b0, '0);

        send_idle_pct = 16;
        recv_idle_pct = 81;
        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                if (i == 0 || !plan[i-1].is_reg) drain();
                reg_write(plan[i].idx, plan[i].value);
            end else begin
                send_word(plan[i].smp, plan[i].typed, plan[i].result);
            end
        end
        run_random_phases();

        send_idle_pct = 81;
        recv_idle_pct = 16;
        run_random_phases();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phases();

        drain();
        repeat (40) @(negedge i_clk);
        $display("Checked %0d filtered words from %0d samples with %0d register writes.",
                 n_checked, n_samples, n_writes);
        $display("Accumulator saturated on %0d steps; %0d mismatches seen.",
                 n_acc_clamps, n_errors);
        if (n_errors == 0 && filtered_q.size() == 0) begin
            $display("first_order_lowpass_filter_unit test passed");
        end else begin
            $display("first_order_lowpass_filter_unit test failed");
        end
        $finish;
    end

    initial begin
        #(100_000_000);
        $display("Timed out with %0d filtered words outstanding.", filtered_q.size());
        $display("first_order_lowpass_filter_unit test failed");
        $finish;
    end

endmodule
